### design/assert_macros.svh
// Assertion helpers for the design files (included by krt_datapath).
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define KRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/krt_pkg.sv
package krt_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned NAME_BYTES = 8;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned NAME_W  = 8 * NAME_BYTES;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned COUNT_W = ($clog2(ENTRIES + 1) > 5) ? $clog2(ENTRIES + 1) : 5;
  localparam int unsigned REC_W   = KEY_W + NAME_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SELECT = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FIN
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic rd_en;
    logic cmp_en;
    logic idx_inc;
    logic commit;
  } krt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_idx;
    logic out_free;
  } krt_sts_t;

endpackage

### design/krt_ram.sv
module krt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/krt_ctrl.sv
module krt_ctrl
  import krt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  krt_sts_t sts_i,
  output krt_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp_en = 1'b1;
        if (sts_i.last_idx) begin
          state_d = S_FIN;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_READ;
        end
      end
      S_FIN: begin
        // hold the result until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### design/krt_datapath.sv
`include "assert_macros.svh"

module krt_datapath
  import krt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  krt_cmd_t            cmd_i,
  output krt_sts_t            sts_o,
  input  logic [1:0]          opcode_i,
  input  logic signed [31:0]  key_i,
  input  logic [63:0]         name_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [63:0]         name_out_o,
  output logic [4:0]          live_count_o
);

  // command registers
  op_e               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [NAME_W-1:0] name_q;

  // scan state
  logic [IDX_W-1:0]  idx_q;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [NAME_W-1:0] hit_name_q;
  logic              free_q;
  logic [IDX_W-1:0]  free_idx_q;

  // table state
  logic [ENTRIES-1:0] valid_q;
  logic [COUNT_W-1:0] count_q, count_d;

  // result register
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [NAME_W-1:0] nout_q, nout_d;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic              set_v, clr_v;
  logic [REC_W-1:0]  rd_rec;
  logic [KEY_W-1:0]  rd_key;
  logic [NAME_W-1:0] rd_name;
  logic              rd_match;

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en & cmd_i.commit),
    .waddr_i (wr_idx),
    .wdata_i ({key_q, name_q}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_rec)
  );

  assign rd_key   = rd_rec[REC_W-1:NAME_W];
  assign rd_name  = rd_rec[NAME_W-1:0];
  assign rd_match = valid_q[idx_q] && (rd_key == key_q);

  assign sts_o.last_idx = (idx_q == IDX_W'(ENTRIES - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(opcode_i);
      key_q  <= key_i;
      name_q <= name_in_i[NAME_W-1:0];
    end
    if (cmd_i.cmp_en && rd_match && !hit_q) begin
      hit_idx_q  <= idx_q;
      hit_name_q <= rd_name;
    end
    if (cmd_i.cmp_en && !valid_q[idx_q] && !free_q) begin
      free_idx_q <= idx_q;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      nout_q   <= nout_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.cmp_en && rd_match) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.cmp_en && !valid_q[idx_q]) begin
        free_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        count_q <= count_d;
        if (set_v) begin
          valid_q[free_idx_q] <= 1'b1;
        end
        if (clr_v) begin
          valid_q[hit_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // resolve the command from the scan results
  always_comb begin
    status_d = ST_OK;
    nout_d   = '0;
    wr_en    = 1'b0;
    wr_idx   = hit_idx_q;
    set_v    = 1'b0;
    clr_v    = 1'b0;
    count_d  = count_q;
    unique case (op_q)
      OP_INSERT: begin
        priority if (hit_q) begin
          status_d = ST_EXISTS;
        end else if (free_q) begin
          wr_en   = 1'b1;
          wr_idx  = free_idx_q;
          set_v   = 1'b1;
          count_d = count_q + COUNT_W'(1);
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_SELECT: begin
        if (hit_q) begin
          nout_d = hit_name_q;
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      OP_UPDATE: begin
        if (hit_q) begin
          wr_en = 1'b1;
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      OP_DELETE: begin
        if (hit_q) begin
          clr_v = 1'b1;
          if (count_q != '0) begin
            count_d = count_q - COUNT_W'(1);
          end
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign name_out_o   = 64'(nout_q);
  assign live_count_o = count_q[4:0];

  `KRT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= COUNT_W'(ENTRIES))
  `KRT_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(valid_q) == 32'(count_q))
  `KRT_ASSERT_NOW(a_commit_needs_room, cmd_i.commit, !out_valid_q || out_ready_i)
  `KRT_ASSERT_NEXT(a_commit_shows_result, cmd_i.commit, out_valid_q)

endmodule

### design/keyed_record_table.sv
// Keyed record table: ENTRIES records, each a valid mark, a 32-bit key and a
// name word of NAME_BYTES bytes.
//
// Input channel (in_valid_i / in_ready_o): one beat is one command made of
// opcode_i, key_i and name_in_i. Insert, select, update and delete.
// Output channel (out_valid_o / out_ready_i): one beat per command with
// status_o, name_out_o (stored name on a successful select, zero otherwise)
// and live_count_o (valid records after the command).
//
// Timing: every command scans the whole table through one record RAM with a
// registered read, each entry read and then compared; after the last entry
// the result is committed to the output register, and only after that commit
// is the next command beat taken.
// The scan goes through the RAM's single read port and the compare stage behind it.
//
// Reset clears all valid marks and the live count at once; no clearing pass
// runs, so the first command may be sent right after reset.
// A stalled receiver: the finished result sits in the output register while
// the next command is taken and scanned; that command then holds at its end
// until the output register is free.
module keyed_record_table
  import krt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // command beat
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] key_i,
  input  logic [63:0]        name_in_i,
  // result beat
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [63:0]        name_out_o,
  output logic [4:0]         live_count_o
);

  krt_cmd_t cmd;
  krt_sts_t sts;

  // sequence the scan and the final commit
  krt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // record storage, key compare, free-slot tracking and result register
  krt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (opcode_i),
    .key_i        (key_i),
    .name_in_i    (name_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .name_out_o   (name_out_o),
    .live_count_o (live_count_o)
  );

endmodule

### tb/keyed_record_table_tb.sv
module keyed_record_table_tb;
  import krt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Length of one command's table scan; the final wait adds a margin on top.
  localparam int unsigned SCAN_CYCLES = 2 * ENTRIES + 2;
  localparam int unsigned KEY_POOL    = 24;
  localparam int unsigned HOLD_LONG   = 300;

  typedef struct packed {
    status_e     status;
    logic [63:0] name;
    logic [4:0]  count;
  } outcome_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         opcode_i;
  logic signed [31:0] key_i;
  logic [63:0]        name_in_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic [63:0]        name_out_o;
  logic [4:0]         live_count_o;

  // Shadow copy of the table, updated as each command beat is accepted.
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_key   [ENTRIES];
  logic [63:0] tbl_name  [ENTRIES];
  int unsigned tbl_total;

  outcome_t    pending_outcomes[$];
  logic [31:0] key_pool[KEY_POOL];

  // Idle controls for the sender (tx_idle) and the result sink (rx_idle, hold_cycles).
  bit          tx_idle;
  bit          rx_idle;
  int unsigned hold_cycles;

  int unsigned error_count;
  int unsigned cmds_sent;
  int unsigned results_seen;
  int unsigned status_seen[4];

  keyed_record_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .key_i        (key_i),
    .name_in_i    (name_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .name_out_o   (name_out_o),
    .live_count_o (live_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10ms;
    $display("timeout at %0t with %0d results outstanding", $time, pending_outcomes.size());
    $display("status: fail");
    $finish;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  // Apply one command to the shadow table and return the result it must produce.
  // Keys match on raw bits; duplicates are checked before a free slot is searched.
  function automatic outcome_t apply_command(op_e op, logic [31:0] key, logic [63:0] name);
    outcome_t    res;
    int          hit;
    logic [63:0] kept;
    hit  = -1;
    kept = 64'(name[NAME_W-1:0]);
    res  = '{status: ST_OK, name: '0, count: '0};
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == key) hit = i;
    end
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          res.status = ST_EXISTS;
        end else begin
          res.status = ST_FULL;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!tbl_valid[i]) begin
              tbl_valid[i] = 1'b1;
              tbl_key[i]   = key;
              tbl_name[i]  = kept;
              tbl_total++;
              res.status   = ST_OK;
              break;
            end
          end
        end
      end
      OP_SELECT: begin
        if (hit >= 0) res.name = tbl_name[hit];
        else res.status = ST_NOTFOUND;
      end
      OP_UPDATE: begin
        if (hit >= 0) tbl_name[hit] = kept;
        else res.status = ST_NOTFOUND;
      end
      default: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          tbl_key[hit]   = '0;
          tbl_name[hit]  = '0;
          if (tbl_total > 0) tbl_total--;
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
    endcase
    res.count = 5'(tbl_total);
    return res;
  endfunction

  // Offer one command beat and hold it until accepted. Called at a rising edge;
  // returns at the edge that took the beat, with valid still high.
  task automatic send_command(op_e op, logic [31:0] key, logic [63:0] name);
    int unsigned gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_i      <= key;
    name_in_i  <= name;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(apply_command(op, key, name));
    cmds_sent++;
  endtask

  // Drop valid and wait for every expected result to drain.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Delete every live record so the next phase starts from an empty table.
  task automatic clear_table();
    logic [31:0] live_keys[$];
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i]) live_keys.push_back(tbl_key[i]);
    end
    foreach (live_keys[i]) send_command(OP_DELETE, live_keys[i], {$urandom(), $urandom()});
  endtask

  // Extreme keys and names, every opcode, hits and misses.
  task automatic test_directed_basics();
    send_command(OP_INSERT, 32'h8000_0000, '1);
    send_command(OP_INSERT, 32'h7FFF_FFFF, 64'h0123_4567_89AB_CDEF);
    send_command(OP_INSERT, 32'h0000_0000, '0);
    send_command(OP_INSERT, 32'hFFFF_FFFF, {$urandom(), $urandom()});
    // duplicate key: refused, count unchanged
    send_command(OP_INSERT, 32'h7FFF_FFFF, 64'hDEAD_BEEF_0000_0001);
    send_command(OP_SELECT, 32'h8000_0000, '0);
    send_command(OP_SELECT, 32'h0000_0001, '1);
    send_command(OP_UPDATE, 32'hFFFF_FFFF, 64'hA5A5_5A5A_F0F0_0F0F);
    send_command(OP_UPDATE, 32'h0000_0002, '1);
    send_command(OP_DELETE, 32'h0000_0000, '1);
    // deleted record is gone: second delete misses
    send_command(OP_DELETE, 32'h0000_0000, '0);
    // reuse the slot freed above
    send_command(OP_INSERT, 32'h0000_0005, 64'h5555_AAAA_5555_AAAA);
  endtask

  // Fill every slot, hit the full table with a new key and a duplicate, then free one slot and retry.
  task automatic test_table_full();
    for (int i = tbl_total; i < ENTRIES; i++) begin
      send_command(OP_INSERT, 32'h5A5A_0000 + i, {$urandom(), $urandom()});
    end
    send_command(OP_INSERT, 32'h1234_5678, {$urandom(), $urandom()});
    send_command(OP_INSERT, 32'h8000_0000, '0);
    send_command(OP_DELETE, 32'h7FFF_FFFF, '0);
    send_command(OP_INSERT, 32'h1234_5678, '1);
  endtask

  // Random commands on a small key pool so hits, duplicates and a full table
  // are common; a tenth of the keys are fresh random values that mostly miss.
  task automatic test_random_mix(int unsigned count, int unsigned w_ins, int unsigned w_sel,
                                 int unsigned w_upd);
    int unsigned roll;
    op_e         op;
    logic [31:0] key;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < w_ins) op = OP_INSERT;
      else if (roll < w_ins + w_sel) op = OP_SELECT;
      else if (roll < w_ins + w_sel + w_upd) op = OP_UPDATE;
      else op = OP_DELETE;
      key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, KEY_POOL - 1)];
      send_command(op, key, {$urandom(), $urandom()});
    end
  endtask

  // Hold the result side off for a long stretch while commands keep coming,
  // so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    wait_idle();
    hold_cycles = HOLD_LONG;
    repeat (6) begin
      send_command(OP_INSERT, $urandom(), {$urandom(), $urandom()});
    end
    wait_idle();
  endtask

  // Result sink: check each accepted result beat against the oldest expectation,
  // then decide whether to take the next one.
  initial begin : result_sink
    int unsigned stall_left;
    outcome_t    want;
    stall_left  = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing expected: status %0d name %h count %0d",
                   $time, status_o, name_out_o, live_count_o);
        end else begin
          want = pending_outcomes.pop_front();
          status_seen[want.status]++;
          if (status_o !== want.status) begin
            error_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          end
          if (name_out_o !== want.name) begin
            error_count++;
            $display("%0t: name_out expected %h actual %h", $time, want.name, name_out_o);
          end
          if (live_count_o !== want.count) begin
            error_count++;
            $display("%0t: live_count expected %0d actual %0d", $time, want.count,
                     live_count_o);
          end
        end
      end
      // Long hold-off counts down here; otherwise stall at random.
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_left = rx_idle ? pick_gap() : 0;
        out_ready_i <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_name[i]  = '0;
    end
    tbl_total    = 0;
    error_count  = 0;
    cmds_sent    = 0;
    results_seen = 0;
    hold_cycles  = 0;
    status_seen  = '{default: 0};
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    opcode_i   <= OP_INSERT;
    key_i      <= '0;
    name_in_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_basics();
    test_table_full();
    clear_table();

    // Insert-heavy: drive the table to full and keep it there.
    test_random_mix(270, 55, 20, 10);
    // Delete-heavy: drain and refill around the empty end.
    test_random_mix(270, 30, 20, 15);
    clear_table();
    // Balanced, with no gaps on either side.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_mix(270, 40, 25, 15);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    clear_table();
    test_random_mix(270, 40, 20, 20);

    test_output_backpressure();

    // Let any stray beat show up before judging.
    wait_idle();
    repeat (SCAN_CYCLES + 8) @(posedge clk_i);

    $display("ran %0d commands, checked %0d results", cmds_sent, results_seen);
    $display("outcomes: ok %0d, exists %0d, full %0d, not found %0d; long output hold done",
             status_seen[ST_OK], status_seen[ST_EXISTS], status_seen[ST_FULL],
             status_seen[ST_NOTFOUND]);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
